>>> hw/rtl/ccdc_pkg.sv
// ----------------------------------------------------------------------------
// ccdc_pkg
// Shared types, constants and helpers of the color cell demodulator with
// its 32-bit mod-2 division check.
// ----------------------------------------------------------------------------
package ccdc_pkg;

	// Largest number of symbols taken in one frame.
	localparam int unsigned MAX_CELLS   = 4608;
	localparam int unsigned CNT_W       = $clog2(MAX_CELLS + 1);
	localparam int unsigned BITS_W      = 14;
	localparam int unsigned DELAY_DEPTH = 16;
	localparam int unsigned SLOT_W      = $clog2(DELAY_DEPTH);
	localparam int unsigned OQ_DEPTH    = 4;
	localparam int unsigned OQ_PTR_W    = $clog2(OQ_DEPTH);
	localparam int unsigned OQ_CNT_W    = $clog2(OQ_DEPTH + 1);

	localparam logic [31:0] DIVISOR = 32'h8260_8EDB;

	localparam logic [7:0] WHITE_LEVEL_RST  = 8'd180;
	localparam logic [7:0] YELLOW_FLOOR_RST = 8'd100;

	localparam logic [1:0] SYM_YELLOW = 2'b00;
	localparam logic [1:0] SYM_RED    = 2'b01;
	localparam logic [1:0] SYM_GREEN  = 2'b10;
	localparam logic [1:0] SYM_BLUE   = 2'b11;

	typedef enum logic {
		REG_WHITE_LEVEL  = 1'b0,
		REG_YELLOW_FLOOR = 1'b1
	} reg_idx_t;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_STATUS  = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FAIL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// Classification of one cell.
	typedef struct packed {
		logic       white;
		logic       sym_valid;
		logic [1:0] sym;
	} cls_t;

	// One result item as it travels to the output queue.
	typedef struct packed {
		kind_t             kind;
		logic [1:0]        symbol;
		status_t           status;
		logic [BITS_W-1:0] payload_bits;
		logic              white_seen;
		logic              last;
	} result_t;

	// One step of the mod-2 long division, bit 31 aligned with the new bit.
	function automatic logic [31:0] divide_bit(input logic [31:0] window,
	                                           input logic        data_bit);
		logic [31:0] w;
		w = (data_bit ^ window[31]) ? (window ^ DIVISOR) : window;
		return {w[30:0], 1'b0};
	endfunction

endpackage

>>> hw/rtl/ccdc_classify.sv
// ----------------------------------------------------------------------------
// ccdc_classify
// Sorts one color cell into white, one of four symbols, or no symbol,
// using exact integer 3:2 ratio tests.
// ----------------------------------------------------------------------------
module ccdc_classify
	import ccdc_pkg::*;
(
	input  logic [7:0] blue,
	input  logic [7:0] green,
	input  logic [7:0] red,
	input  logic [7:0] white_level,
	input  logic [7:0] yellow_floor,
	output cls_t       cls
);

	logic [9:0] b2, g2, r2, b3, g3, r3;

	assign b2 = {1'b0, blue, 1'b0};
	assign g2 = {1'b0, green, 1'b0};
	assign r2 = {1'b0, red, 1'b0};
	assign b3 = b2 + {2'b00, blue};
	assign g3 = g2 + {2'b00, green};
	assign r3 = r2 + {2'b00, red};

	always_comb begin
		cls.white     = (blue > white_level) && (green > white_level) && (red > white_level);
		cls.sym_valid = 1'b1;
		if ((green > yellow_floor) && (red > yellow_floor) && (b2 < g3) && (b2 < r3)) begin
			cls.sym = SYM_YELLOW;
		end else if ((b3 < r2) && (g3 < r2)) begin
			cls.sym = SYM_RED;
		end else if ((b3 < g2) && (r3 < g2)) begin
			cls.sym = SYM_GREEN;
		end else if ((g3 < b2) && (r3 < b2)) begin
			cls.sym = SYM_BLUE;
		end else begin
			cls.sym       = SYM_YELLOW;
			cls.sym_valid = 1'b0;
		end
	end

endmodule

>>> hw/rtl/ccdc_frame.sv
// ----------------------------------------------------------------------------
// ccdc_frame
// Frame state: symbol delay line, symbol count, division window and the
// early-end flag. Builds up to two results for each cell it takes.
// ----------------------------------------------------------------------------
module ccdc_frame
	import ccdc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  cls_t    cls,
	input  logic    last_cell,
	output logic [1:0] push_n,
	output result_t res0,
	output result_t res1
);

	logic [31:0]      window_q, window_n, window_sym;
	logic [CNT_W-1:0] count_q, count_n;
	logic             done_q, done_n;
	logic [1:0]       delay_q [DELAY_DEPTH];
	logic             wr_en;
	logic [SLOT_W-1:0] slot;
	logic             sym_take;
	logic [1:0]       n;

	function automatic result_t make_status(input logic [CNT_W-1:0] cnt,
	                                        input logic [31:0]      window,
	                                        input logic             white);
		result_t    r;
		logic [CNT_W:0] twice;
		twice          = {cnt, 1'b0} - (CNT_W + 1)'(2 * DELAY_DEPTH);
		r.kind         = KIND_STATUS;
		r.symbol       = '0;
		r.white_seen   = white;
		r.last         = 1'b1;
		r.payload_bits = '0;
		if (cnt == '0) begin
			r.status = ST_EMPTY;
		end else if (cnt < CNT_W'(DELAY_DEPTH)) begin
			r.status = ST_FAIL;
		end else begin
			r.status       = (window == '0) ? ST_OK : ST_FAIL;
			r.payload_bits = BITS_W'(twice);
		end
		return r;
	endfunction

	assign slot       = count_q[SLOT_W-1:0];
	assign sym_take   = cls.sym_valid && (count_q < CNT_W'(MAX_CELLS));
	assign window_sym = divide_bit(divide_bit(window_q, cls.sym[1]), cls.sym[0]);

	always_comb begin
		window_n = window_q;
		count_n  = count_q;
		done_n   = done_q;
		wr_en    = 1'b0;
		n        = 2'd0;
		res0     = '0;
		res1     = '0;
		if (done_q) begin
			if (last_cell) begin
				window_n = '0;
				count_n  = '0;
				done_n   = 1'b0;
			end
		end else if (cls.white) begin
			res0 = make_status(count_q, window_q, 1'b1);
			n    = 2'd1;
			if (last_cell) begin
				window_n = '0;
				count_n  = '0;
			end else begin
				done_n = 1'b1;
			end
		end else begin
			if (sym_take) begin
				window_n = window_sym;
				count_n  = count_q + 1'b1;
				wr_en    = 1'b1;
				if (count_q >= CNT_W'(DELAY_DEPTH)) begin
					res0.kind   = KIND_PAYLOAD;
					res0.symbol = delay_q[slot];
					res0.last   = !last_cell;
					n           = 2'd1;
				end
			end
			if (last_cell) begin
				if (n == 2'd0) begin
					res0 = make_status(count_n, window_n, 1'b0);
				end else begin
					res1 = make_status(count_n, window_n, 1'b0);
				end
				n        = n + 2'd1;
				window_n = '0;
				count_n  = '0;
			end
		end
	end

	assign push_n = fire ? n : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			count_q  <= '0;
			done_q   <= 1'b0;
		end else if (fire) begin
			window_q <= window_n;
			count_q  <= count_n;
			done_q   <= done_n;
		end
	end

	// Slots are always written before they are read back, so no clearing.
	always_ff @(posedge clk) begin
		if (fire && wr_en) begin
			delay_q[slot] <= cls.sym;
		end
	end

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		push_n == 2'd2 |-> res0.kind == KIND_PAYLOAD && res1.kind == KIND_STATUS)
		else $error("two results must be a payload symbol followed by the status");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_CELLS))
		else $error("symbol count passed its limit");

	a_empty_window: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 |-> window_q == '0)
		else $error("division window holds bits with no symbols taken");

	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> $past(fire && cls.white && !last_cell))
		else $error("frame ended early without a white cell");

endmodule

>>> hw/rtl/ccdc_out_fifo.sv
// ----------------------------------------------------------------------------
// ccdc_out_fifo
// Small result queue that takes up to two results a cycle and hands out
// one result per transfer.
// ----------------------------------------------------------------------------
module ccdc_out_fifo
	import ccdc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] push_n,
	input  result_t    res0,
	input  result_t    res1,
	output logic       room,
	output logic       res_valid,
	input  logic       res_ready,
	output result_t    head
);

	result_t              mem_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0]  wr_q, rd_q;
	logic [OQ_CNT_W-1:0]  cnt_q;
	logic                 pop;

	assign res_valid = (cnt_q != '0);
	assign pop       = res_valid && res_ready;
	assign head      = mem_q[rd_q];
	assign room      = (cnt_q <= OQ_CNT_W'(OQ_DEPTH - 2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + OQ_PTR_W'(push_n);
			rd_q  <= rd_q + OQ_PTR_W'(pop);
			cnt_q <= cnt_q + OQ_CNT_W'(push_n) - OQ_CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_q] <= res0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_q + 1'b1] <= res1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push_n != 2'd0 |-> cnt_q <= OQ_CNT_W'(OQ_DEPTH - 2))
		else $error("result queue written without room");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= OQ_CNT_W'(OQ_DEPTH))
		else $error("result queue count out of range");

	a_push_code: assert property (@(posedge clk) disable iff (!arst_n)
		push_n != 2'd3)
		else $error("more than two results pushed in one cycle");

endmodule

>>> hw/rtl/color_cell_demod_crc_check.sv
// ----------------------------------------------------------------------------
// color_cell_demod_crc_check
// Four-color cell demodulator with a 32-bit mod-2 division check.
// ----------------------------------------------------------------------------
// The block takes one sampled color cell per transfer on the cell channel and
// can take a new cell in every clock cycle. A cell is registered, then
// classified and folded into the frame state once the result queue has room.
// Its first result passes through the input stage register and the result
// queue before it is offered on the result channel. Most cells
// cause at most one result; the final cell of a frame may cause a payload
// symbol and the frame status, which take two result transfers. A four-entry
// result queue between the frame logic and the result port absorbs this, so
// the sustained rate is one cell per cycle as long as results are taken as
// fast as they are made; the cell channel stalls only when the queue has
// fewer than two free entries. Payload symbols leave sixteen symbols late,
// so the 32 check bits at the end of a frame are never shown as payload.
// The two thresholds are written through the APB-style port at byte
// addresses 0 (white level) and 4 (yellow floor); the user must write them
// only while the block has no work in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module color_cell_demod_crc_check
	import ccdc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,

	// Cell channel.
	input  logic        cell_valid,
	output logic        cell_ready,
	input  logic [7:0]  blue,
	input  logic [7:0]  green,
	input  logic [7:0]  red,
	input  logic        frame_last_cell,

	// Result channel.
	output logic        res_valid,
	input  logic        res_ready,
	output logic        kind,
	output logic [1:0]  symbol,
	output logic [1:0]  status,
	output logic [13:0] payload_bits,
	output logic        white_seen,
	output logic        last
);

	logic [7:0] white_level_q, yellow_floor_q;
	reg_idx_t   reg_idx;
	logic       cfg_wr;

	// Input stage: one cell held until the frame logic takes it.
	logic       valid_s1;
	logic [7:0] blue_s1, green_s1, red_s1;
	logic       last_s1;
	logic       fire;

	cls_t       cls;
	logic [1:0] push_n;
	result_t    res0, res1, head;
	logic       room;

	// The register index is the word address; the low address bits select
	// a byte within the word and do not change the target.
	assign reg_idx = reg_idx_t'(paddr[2]);
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			white_level_q  <= WHITE_LEVEL_RST;
			yellow_floor_q <= YELLOW_FLOOR_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_WHITE_LEVEL:  white_level_q  <= pwdata[7:0];
				REG_YELLOW_FLOOR: yellow_floor_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_WHITE_LEVEL:  prdata = {24'd0, white_level_q};
			REG_YELLOW_FLOOR: prdata = {24'd0, yellow_floor_q};
			default:          prdata = '0;
		endcase
	end

	// The held cell moves on when the result queue can take two results.
	// A new cell is taken whenever the input stage is empty or emptying.
	assign fire       = valid_s1 && room;
	assign cell_ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cell_ready) begin
			valid_s1 <= cell_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cell_valid && cell_ready) begin
			blue_s1  <= blue;
			green_s1 <= green;
			red_s1   <= red;
			last_s1  <= frame_last_cell;
		end
	end

	ccdc_classify u_classify (
		.blue         (blue_s1),
		.green        (green_s1),
		.red          (red_s1),
		.white_level  (white_level_q),
		.yellow_floor (yellow_floor_q),
		.cls          (cls)
	);

	ccdc_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.cls       (cls),
		.last_cell (last_s1),
		.push_n    (push_n),
		.res0      (res0),
		.res1      (res1)
	);

	ccdc_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.res0      (res0),
		.res1      (res1),
		.room      (room),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.head      (head)
	);

	assign kind         = head.kind;
	assign symbol       = head.symbol;
	assign status       = head.status;
	assign payload_bits = head.payload_bits;
	assign white_seen   = head.white_seen;
	assign last         = head.last;

endmodule
